FILE: design/rdiv_pkg.sv
// shared types and constants for the restoring divider
package rdiv_pkg;

	// default operand width
	localparam int unsigned WIDTH_DEF = 32;

	// width of the payload ports
	localparam int unsigned FIELD_W = 32;

	// operation codes on op
	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED   = 1'b1;

	// sign fix-up flags that ride along with each item
	typedef struct packed {
		logic neg_q;
		logic neg_r;
	} rdiv_side_t;

endpackage

FILE: design/rdiv_step.sv
// one restoring division stage: one quotient bit, registered, with its own valid
module rdiv_step #(
	parameter int unsigned WIDTH = rdiv_pkg::WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  logic [WIDTH-1:0]        up_rem,
	input  logic [WIDTH-1:0]        up_acc,
	input  logic [WIDTH-1:0]        up_den,
	input  rdiv_pkg::rdiv_side_t    up_side,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output logic [WIDTH-1:0]        dn_rem,
	output logic [WIDTH-1:0]        dn_acc,
	output logic [WIDTH-1:0]        dn_den,
	output rdiv_pkg::rdiv_side_t    dn_side
);

	logic                 vld_s1;
	logic [WIDTH-1:0]     rem_s1;
	logic [WIDTH-1:0]     acc_s1;
	logic [WIDTH-1:0]     den_s1;
	rdiv_pkg::rdiv_side_t side_s1;

	logic [WIDTH:0]       sh;
	logic [WIDTH+1:0]     diff;
	logic                 fits;
	logic                 load;

	// shifted partial remainder with the next dividend bit, one bit wider
	assign sh   = {up_rem, up_acc[WIDTH-1]};
	assign diff = {1'b0, sh} - {2'b00, up_den};
	assign fits = ~diff[WIDTH+1];

	assign up_ready = ~vld_s1 | dn_ready;
	assign load     = up_valid & up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_s1  <= fits ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
			acc_s1  <= {up_acc[WIDTH-2:0], fits};
			den_s1  <= up_den;
			side_s1 <= up_side;
		end
	end

	assign dn_valid = vld_s1;
	assign dn_rem   = rem_s1;
	assign dn_acc   = acc_s1;
	assign dn_den   = den_s1;
	assign dn_side  = side_s1;

endmodule

FILE: design/restoring_integer_divider_top.sv
// top level of the pipelined signed/unsigned restoring divider
// Pipelined restoring divider. Each item carries op (0 unsigned, 1 signed two's
// complement), a dividend and a divisor, and yields one result with quotient and
// remainder. Signed mode truncates toward zero: the remainder takes the sign of
// the dividend, the most negative value divided by minus one returns itself with
// a zero remainder. Division by zero gives an all-ones quotient (minus one in
// signed mode, plus one for a negative signed dividend) and the dividend as the
// remainder. An item passes through WIDTH + 2 register stages: one stage forms
// the operand magnitudes, WIDTH stages each settle one quotient bit with a
// WIDTH + 1 bit subtract, and one stage applies the sign fix-up and holds the
// result for the output handshake. A new item can enter every cycle while the output
// is not stalled. Each stage has its own valid bit and advances whenever the stage
// after it is empty or moving, so a stalled output only blocks the items that pile
// up behind it and bubbles close up. Ports are 32 bits wide; at WIDTH below 32 the
// upper input bits are ignored and the upper output bits read zero, above 32 the
// operands are zero-extended and the results truncated to 32 bits.
module restoring_integer_divider_top #(
	parameter int unsigned WIDTH = rdiv_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [rdiv_pkg::FIELD_W-1:0]  dividend,
	input  logic [rdiv_pkg::FIELD_W-1:0]  divisor,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rdiv_pkg::FIELD_W-1:0]  quotient,
	output logic [rdiv_pkg::FIELD_W-1:0]  remainder
);

	// common width that holds both a port and an operand
	localparam int unsigned EXT_W = (WIDTH > rdiv_pkg::FIELD_W) ? WIDTH : rdiv_pkg::FIELD_W;

	// ---- operand magnitudes ----
	logic [EXT_W-1:0]     a_ext;
	logic [EXT_W-1:0]     b_ext;
	logic [WIDTH-1:0]     a_w;
	logic [WIDTH-1:0]     b_w;
	logic                 sa;
	logic                 sb;
	logic                 load_s1;

	logic                 vld_s1;
	logic [WIDTH-1:0]     num_s1;
	logic [WIDTH-1:0]     den_s1;
	rdiv_pkg::rdiv_side_t side_s1;

	// pipeline chain: index 0 is the magnitude stage, index WIDTH the last step
	logic                 vld_a  [0:WIDTH];
	logic                 rdy_a  [0:WIDTH];
	logic [WIDTH-1:0]     rem_a  [0:WIDTH];
	logic [WIDTH-1:0]     acc_a  [0:WIDTH];
	logic [WIDTH-1:0]     den_a  [0:WIDTH];
	rdiv_pkg::rdiv_side_t side_a [0:WIDTH];

	// ---- fix-up and output stage ----
	logic                 vld_s3;
	logic [WIDTH-1:0]     q_s3;
	logic [WIDTH-1:0]     r_s3;
	logic                 load_s3;
	logic [EXT_W-1:0]     q_ext;
	logic [EXT_W-1:0]     r_ext;

	// zero-extend or trim the ports to the operand width
	assign a_ext = EXT_W'(dividend);
	assign b_ext = EXT_W'(divisor);
	assign a_w   = a_ext[WIDTH-1:0];
	assign b_w   = b_ext[WIDTH-1:0];

	// operand signs only count in signed mode
	assign sa = (op == rdiv_pkg::OP_SIGNED) & a_w[WIDTH-1];
	assign sb = (op == rdiv_pkg::OP_SIGNED) & b_w[WIDTH-1];

	assign in_ready = ~vld_s1 | rdy_a[0];
	assign load_s1  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			num_s1        <= sa ? (~a_w + WIDTH'(1'b1)) : a_w;
			den_s1        <= sb ? (~b_w + WIDTH'(1'b1)) : b_w;
			// quotient flips on differing signs, remainder follows the dividend
			side_s1.neg_q <= sa ^ sb;
			side_s1.neg_r <= sa;
		end
	end

	// partial remainder starts at zero, dividend bits shift out of the top of acc
	assign vld_a[0]  = vld_s1;
	assign rem_a[0]  = '0;
	assign acc_a[0]  = num_s1;
	assign den_a[0]  = den_s1;
	assign side_a[0] = side_s1;

	// one stage per quotient bit, most significant first
	for (genvar i = 0; i < WIDTH; i++) begin : g_step
		rdiv_step #(
			.WIDTH (WIDTH)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld_a[i]),
			.up_ready (rdy_a[i]),
			.up_rem   (rem_a[i]),
			.up_acc   (acc_a[i]),
			.up_den   (den_a[i]),
			.up_side  (side_a[i]),
			.dn_valid (vld_a[i+1]),
			.dn_ready (rdy_a[i+1]),
			.dn_rem   (rem_a[i+1]),
			.dn_acc   (acc_a[i+1]),
			.dn_den   (den_a[i+1]),
			.dn_side  (side_a[i+1])
		);
	end

	// output register: takes the last step's item when empty or being drained
	assign rdy_a[WIDTH] = ~vld_s3 | out_ready;
	assign load_s3      = vld_a[WIDTH] & rdy_a[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_a[WIDTH]) begin
			vld_s3 <= vld_a[WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			q_s3 <= side_a[WIDTH].neg_q ? (~acc_a[WIDTH] + WIDTH'(1'b1)) : acc_a[WIDTH];
			r_s3 <= side_a[WIDTH].neg_r ? (~rem_a[WIDTH] + WIDTH'(1'b1)) : rem_a[WIDTH];
		end
	end

	assign q_ext     = EXT_W'(q_s3);
	assign r_ext     = EXT_W'(r_s3);
	assign out_valid = vld_s3;
	assign quotient  = q_ext[rdiv_pkg::FIELD_W-1:0];
	assign remainder = r_ext[rdiv_pkg::FIELD_W-1:0];

	// ---- checks ----

	// a nonzero divisor always leaves a remainder magnitude below it
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_a[WIDTH] && (den_a[WIDTH] != '0) |-> (rem_a[WIDTH] < den_a[WIDTH]))
		else $error("remainder magnitude not below divisor");

	// a zero divisor sets every quotient bit
	a_div0_ones: assert property (@(posedge clk) disable iff (!arst_n)
		vld_a[WIDTH] && (den_a[WIDTH] == '0) |-> (&acc_a[WIDTH]))
		else $error("division by zero did not give all-ones magnitude");

	// an accepted item lands in the magnitude stage
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted item lost at magnitude stage");

	// a result taken by the consumer always frees the last step to advance
	a_drain_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> rdy_a[WIDTH])
		else $error("output stage blocks while drained");

endmodule
